// ===== rtl/dirty_line_writeback_tracker_unit_macros.svh =====
// assertion helpers for the dirty line tracker
`ifndef DIRTY_LINE_WRITEBACK_TRACKER_UNIT_MACROS_SVH
`define DIRTY_LINE_WRITEBACK_TRACKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DLWT_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("dlwt same-cycle check failed");
// next-cycle implication
`define DLWT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("dlwt next-cycle check failed");
`else
`define DLWT_ASSERT_IMPL(label, clk, rst, cond, prop)
`define DLWT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== rtl/dlwt_pkg.sv =====
`timescale 1ns / 1ps
package dlwt_pkg;

   localparam int BUFFER_BYTES = 16384;
   localparam int LINE_SHIFT   = 3;
   localparam int NUM_LINES    = 2048;

   // field widths
   localparam int OP_W     = 2;
   localparam int ADDR_W   = 14;
   localparam int DATA_W   = 8;
   localparam int LINE_W   = 11;
   localparam int CNT_W    = 16;

   localparam int HEALTH_WINDOW_RESET = 2000;

   // storage geometry
   localparam int BUF_AW      = $clog2(BUFFER_BYTES);
   localparam int LIDX_W      = $clog2(NUM_LINES);
   localparam int WORD_BITS   = 32;
   localparam int WORD_SHIFT  = $clog2(WORD_BITS);
   localparam int DIRTY_WORDS = NUM_LINES / WORD_BITS;
   localparam int WIDX_W      = $clog2(DIRTY_WORDS);

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERIFY_ENABLED = 1'b0,
      CSR_HEALTH_WINDOW  = 1'b1
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_TICK   = 2'd2,
      OP_REPORT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WIDX_W-1:0]    rd_idx;
      logic                 wr_en;
      logic [WIDX_W-1:0]    wr_idx;
      logic [WORD_BITS-1:0] wr_word;
   } dmap_cmd_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] rd_word;
      logic [WIDX_W-1:0]    low_idx;
      logic                 any_now;
      logic                 any_next;
   } dmap_stat_type;

   // lowest set bit of the summary vector, binary halving
   function automatic logic [WIDX_W-1:0] lowest_word(input logic [DIRTY_WORDS-1:0] vec);
      logic [DIRTY_WORDS-1:0] v;
      logic [WIDX_W-1:0]      idx;
      v   = vec;
      idx = '0;
      for (int lvl = WIDX_W - 1; lvl >= 0; lvl--) begin
         if ((v & ((DIRTY_WORDS'(1) << (1 << lvl)) - DIRTY_WORDS'(1))) == '0) begin
            v        = v >> (1 << lvl);
            idx[lvl] = 1'b1;
         end
      end
      return idx;
   endfunction

   // lowest set bit of one dirty word
   function automatic logic [WORD_SHIFT-1:0] lowest_bit(input logic [WORD_BITS-1:0] vec);
      logic [WORD_BITS-1:0]  v;
      logic [WORD_SHIFT-1:0] idx;
      v   = vec;
      idx = '0;
      for (int lvl = WORD_SHIFT - 1; lvl >= 0; lvl--) begin
         if ((v & ((WORD_BITS'(1) << (1 << lvl)) - WORD_BITS'(1))) == '0) begin
            v        = v >> (1 << lvl);
            idx[lvl] = 1'b1;
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/dlwt_if.sv =====
`timescale 1ns / 1ps
interface dlwt_req_if;
   logic                         valid;
   logic                         ready;
   logic [dlwt_pkg::OP_W-1:0]    operation;
   logic [dlwt_pkg::ADDR_W-1:0]  address;
   logic [dlwt_pkg::DATA_W-1:0]  write_data;
   logic [dlwt_pkg::LINE_W-1:0]  report_line;
   logic                         write_ok;
   logic                         verify_ok;

   modport source (output valid, output operation, output address, output write_data,
                   output report_line, output write_ok, output verify_ok, input ready);
   modport sink   (input valid, input operation, input address, input write_data,
                   input report_line, input write_ok, input verify_ok, output ready);
endinterface

interface dlwt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dlwt_pkg::DATA_W-1:0]  read_data;
   logic                         flush_request;
   logic [dlwt_pkg::LINE_W-1:0]  flush_line;
   logic                         any_dirty;
   logic                         is_healthy;
   logic [dlwt_pkg::CNT_W-1:0]   flush_count;
   logic [dlwt_pkg::CNT_W-1:0]   verify_fail_count;

   modport source (output valid, output read_data, output flush_request, output flush_line,
                   output any_dirty, output is_healthy, output flush_count,
                   output verify_fail_count, input ready);
   modport sink   (input valid, input read_data, input flush_request, input flush_line,
                   input any_dirty, input is_healthy, input flush_count,
                   input verify_fail_count, output ready);
endinterface

// ===== rtl/dlwt_ram.sv =====
`timescale 1ns / 1ps
module dlwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dlwt_dirty_map.sv =====
`timescale 1ns / 1ps
module dlwt_dirty_map (
   input  logic                    clock,
   input  logic                    reset,
   input  dlwt_pkg::dmap_cmd_type  cmd,
   output dlwt_pkg::dmap_stat_type stat
);

   // one summary bit per dirty word; a clear summary bit also means the word reads as zero
   logic [dlwt_pkg::DIRTY_WORDS-1:0] summary_ff;
   logic [dlwt_pkg::DIRTY_WORDS-1:0] summary_in;
   logic                             rd_valid_ff;
   logic [dlwt_pkg::WORD_BITS-1:0]   ram_q;

   dlwt_ram #(
      .WIDTH (dlwt_pkg::WORD_BITS),
      .DEPTH (dlwt_pkg::DIRTY_WORDS)
   ) u_words (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (cmd.wr_idx),
      .wr_data (cmd.wr_word),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_idx),
      .rd_data (ram_q)
   );

   always_comb begin
      summary_in = summary_ff;
      if (cmd.wr_en) begin
         summary_in[cmd.wr_idx] = (cmd.wr_word != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         summary_ff <= '0;
      end else begin
         summary_ff <= summary_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= summary_ff[cmd.rd_idx];
      end
   end

   assign stat.rd_word  = rd_valid_ff ? ram_q : '0;
   assign stat.low_idx  = dlwt_pkg::lowest_word(summary_ff);
   assign stat.any_now  = |summary_ff;
   assign stat.any_next = |summary_in;

endmodule

// ===== rtl/dirty_line_writeback_tracker_unit.sv =====
`timescale 1ns / 1ps
// channel | dir | beat contents                                         | accepted when
// req_if  | in  | operation, address, write_data, report_line, oks      | valid && ready
// rsp_if  | out | read_data, flush req/line, any_dirty, health, counts  | valid && ready
// csr_*   | in  | index, write data                                     | csr_write_enable
//
// each request beat steps through accept, mirror/dirty-word read, execute and write back
// the execute step waits while the previous response beat is still unread
// after reset the mirror is zeroed one byte a cycle across all BUFFER_BYTES (16384), no
// request beat is taken meanwhile; csr writes are taken at any time
// reset is synchronous, active high
`include "dirty_line_writeback_tracker_unit_macros.svh"
module dirty_line_writeback_tracker_unit (
   input  logic                             clock,
   input  logic                             reset,
   dlwt_req_if.sink                         req_if,
   dlwt_rsp_if.source                       rsp_if,
   input  logic                             csr_write_enable,
   input  logic [dlwt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dlwt_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   // control state
   dlwt_pkg::state_type state_ff, state_in;
   logic [dlwt_pkg::BUF_AW-1:0] clear_cnt_ff;
   logic                        finish;

   // configuration registers
   logic                        verify_en_ff;
   logic [dlwt_pkg::CNT_W-1:0]  health_window_ff;

   // counters
   logic [dlwt_pkg::CNT_W-1:0]  idle_ff, idle_in;
   logic [dlwt_pkg::CNT_W-1:0]  flush_cnt_ff, flush_cnt_in;
   logic [dlwt_pkg::CNT_W-1:0]  fail_cnt_ff, fail_cnt_in;

   // captured request beat
   dlwt_pkg::op_type            op_ff;
   logic [dlwt_pkg::ADDR_W-1:0] addr_ff;
   logic [dlwt_pkg::DATA_W-1:0] wdata_ff;
   logic [dlwt_pkg::LINE_W-1:0] rline_ff;
   logic                        wok_ff;
   logic                        vok_ff;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dlwt_pkg::DATA_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic                        rsp_freq_ff, rsp_freq_in;
   logic [dlwt_pkg::LINE_W-1:0] rsp_fline_ff, rsp_fline_in;
   logic                        rsp_any_ff, rsp_any_in;
   logic                        rsp_healthy_ff, rsp_healthy_in;

   // mirror port
   logic                        mir_wr_en;
   logic [dlwt_pkg::BUF_AW-1:0] mir_wr_addr;
   logic [dlwt_pkg::DATA_W-1:0] mir_wr_data;
   logic                        mir_rd_en;
   logic [dlwt_pkg::DATA_W-1:0] mir_q;

   // dirty map
   dlwt_pkg::dmap_cmd_type      dcmd;
   dlwt_pkg::dmap_stat_type     dstat;

   // address decode
   logic                        addr_in_buf;
   logic [31:0]                 wline_full;
   logic                        wline_ok;
   logic [dlwt_pkg::LIDX_W-1:0] wline_idx;
   logic                        rline_ok;
   logic [dlwt_pkg::LIDX_W-1:0] rline_idx;
   logic                        byte_changed;
   logic                        report_act;

   dlwt_ram #(
      .WIDTH (dlwt_pkg::DATA_W),
      .DEPTH (dlwt_pkg::BUFFER_BYTES)
   ) u_mirror (
      .clock   (clock),
      .wr_en   (mir_wr_en),
      .wr_addr (mir_wr_addr),
      .wr_data (mir_wr_data),
      .rd_en   (mir_rd_en),
      .rd_addr (dlwt_pkg::BUF_AW'(addr_ff)),
      .rd_data (mir_q)
   );

   dlwt_dirty_map u_dirty (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .stat  (dstat)
   );

   // address and line decode of the captured beat
   assign addr_in_buf  = 32'(addr_ff) < dlwt_pkg::BUFFER_BYTES;
   assign wline_full   = 32'(addr_ff) >> dlwt_pkg::LINE_SHIFT;
   assign wline_ok     = wline_full < dlwt_pkg::NUM_LINES;
   assign wline_idx    = dlwt_pkg::LIDX_W'(wline_full);
   assign rline_ok     = 32'(rline_ff) < dlwt_pkg::NUM_LINES;
   assign rline_idx    = dlwt_pkg::LIDX_W'(rline_ff);
   // only a changed byte dirties its line
   assign byte_changed = addr_in_buf && (mir_q != wdata_ff);
   // a report counts only for a line in the bitmap and a good flash write
   assign report_act   = rline_ok && wok_ff;

   assign req_if.ready = (state_ff == dlwt_pkg::ST_IDLE);

   // sequencer: next state and memory commands
   always_comb begin
      state_in     = state_ff;
      finish       = 1'b0;
      mir_wr_en    = 1'b0;
      mir_wr_addr  = dlwt_pkg::BUF_AW'(addr_ff);
      mir_wr_data  = wdata_ff;
      mir_rd_en    = 1'b0;
      dcmd.rd_en   = 1'b0;
      dcmd.rd_idx  = dstat.low_idx;
      dcmd.wr_en   = 1'b0;
      dcmd.wr_idx  = wline_idx[dlwt_pkg::LIDX_W-1:dlwt_pkg::WORD_SHIFT];
      dcmd.wr_word = dstat.rd_word
                   | (dlwt_pkg::WORD_BITS'(1) << wline_idx[dlwt_pkg::WORD_SHIFT-1:0]);
      unique case (state_ff)
         dlwt_pkg::ST_CLEAR: begin
            // zero the mirror one byte a cycle
            mir_wr_en   = 1'b1;
            mir_wr_addr = clear_cnt_ff;
            mir_wr_data = '0;
            if (clear_cnt_ff == dlwt_pkg::BUF_AW'(dlwt_pkg::BUFFER_BYTES - 1)) begin
               state_in = dlwt_pkg::ST_IDLE;
            end
         end
         dlwt_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               state_in = dlwt_pkg::ST_READ;
            end
         end
         dlwt_pkg::ST_READ: begin
            mir_rd_en  = 1'b1;
            dcmd.rd_en = 1'b1;
            unique case (op_ff)
               dlwt_pkg::OP_WRITE:  dcmd.rd_idx =
                  wline_idx[dlwt_pkg::LIDX_W-1:dlwt_pkg::WORD_SHIFT];
               dlwt_pkg::OP_REPORT: dcmd.rd_idx =
                  rline_idx[dlwt_pkg::LIDX_W-1:dlwt_pkg::WORD_SHIFT];
               dlwt_pkg::OP_READ,
               dlwt_pkg::OP_TICK:   dcmd.rd_idx = dstat.low_idx;
            endcase
            state_in = dlwt_pkg::ST_EXEC;
         end
         dlwt_pkg::ST_EXEC: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               finish   = 1'b1;
               state_in = dlwt_pkg::ST_IDLE;
               unique case (op_ff)
                  dlwt_pkg::OP_WRITE: begin
                     mir_wr_en  = byte_changed;
                     dcmd.wr_en = byte_changed && wline_ok;
                  end
                  dlwt_pkg::OP_REPORT: begin
                     dcmd.wr_en   = report_act && (!verify_en_ff || vok_ff);
                     dcmd.wr_idx  = rline_idx[dlwt_pkg::LIDX_W-1:dlwt_pkg::WORD_SHIFT];
                     dcmd.wr_word = dstat.rd_word
                        & ~(dlwt_pkg::WORD_BITS'(1) << rline_idx[dlwt_pkg::WORD_SHIFT-1:0]);
                  end
                  dlwt_pkg::OP_READ,
                  dlwt_pkg::OP_TICK: begin
                  end
               endcase
            end
         end
      endcase
   end

   // counters and response fields for the beat being finished
   always_comb begin
      idle_in        = idle_ff;
      flush_cnt_in   = flush_cnt_ff;
      fail_cnt_in    = fail_cnt_ff;
      rsp_rdata_in   = '0;
      rsp_freq_in    = 1'b0;
      rsp_fline_in   = '0;
      case (op_ff)
         dlwt_pkg::OP_READ: begin
            rsp_rdata_in = addr_in_buf ? mir_q : '0;
         end
         dlwt_pkg::OP_TICK: begin
            // idle count runs only while something is dirty
            if (dstat.any_now) begin
               idle_in      = idle_ff + dlwt_pkg::CNT_W'(1);
               rsp_freq_in  = 1'b1;
               rsp_fline_in = dlwt_pkg::LINE_W'({dstat.low_idx,
                                                 dlwt_pkg::lowest_bit(dstat.rd_word)});
            end else begin
               idle_in = '0;
            end
         end
         dlwt_pkg::OP_REPORT: begin
            if (report_act) begin
               flush_cnt_in = flush_cnt_ff + dlwt_pkg::CNT_W'(1);
               if (verify_en_ff && !vok_ff) begin
                  fail_cnt_in = fail_cnt_ff + dlwt_pkg::CNT_W'(1);
               end
            end
         end
         dlwt_pkg::OP_WRITE: begin
         end
      endcase
      rsp_any_in     = dstat.any_next;
      rsp_healthy_in = idle_in < health_window_ff;
      rsp_valid_in   = finish || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlwt_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
         idle_ff      <= '0;
         flush_cnt_ff <= '0;
         fail_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= (state_ff == dlwt_pkg::ST_CLEAR) ?
                         clear_cnt_ff + dlwt_pkg::BUF_AW'(1) : clear_cnt_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            idle_ff      <= idle_in;
            flush_cnt_ff <= flush_cnt_in;
            fail_cnt_ff  <= fail_cnt_in;
         end
      end
   end

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         verify_en_ff     <= 1'b1;
         health_window_ff <= dlwt_pkg::CNT_W'(dlwt_pkg::HEALTH_WINDOW_RESET);
      end else if (csr_write_enable) begin
         if (csr_index == dlwt_pkg::CSR_VERIFY_ENABLED) begin
            verify_en_ff <= csr_write_data[0];
         end
         if (csr_index == dlwt_pkg::CSR_HEALTH_WINDOW) begin
            health_window_ff <= csr_write_data[dlwt_pkg::CNT_W-1:0];
         end
      end
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         op_ff    <= dlwt_pkg::op_type'(req_if.operation);
         addr_ff  <= req_if.address;
         wdata_ff <= req_if.write_data;
         rline_ff <= req_if.report_line;
         wok_ff   <= req_if.write_ok;
         vok_ff   <= req_if.verify_ok;
      end
   end

   // response payload, loaded when a beat finishes
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_rdata_ff   <= rsp_rdata_in;
         rsp_freq_ff    <= rsp_freq_in;
         rsp_fline_ff   <= rsp_fline_in;
         rsp_any_ff     <= rsp_any_in;
         rsp_healthy_ff <= rsp_healthy_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.read_data         = rsp_rdata_ff;
   assign rsp_if.flush_request     = rsp_freq_ff;
   assign rsp_if.flush_line        = rsp_fline_ff;
   assign rsp_if.any_dirty         = rsp_any_ff;
   assign rsp_if.is_healthy        = rsp_healthy_ff;
   assign rsp_if.flush_count       = flush_cnt_ff;
   assign rsp_if.verify_fail_count = fail_cnt_ff;

   // no request beat during the mirror clearing pass
   `DLWT_ASSERT_IMPL(a_clear_blocks_req, clock, reset,
      state_ff == dlwt_pkg::ST_CLEAR, !req_if.ready)
   // execute holds while the response register is occupied
   `DLWT_ASSERT_NEXT(a_exec_waits, clock, reset,
      state_ff == dlwt_pkg::ST_EXEC && rsp_valid_ff && !rsp_if.ready,
      state_ff == dlwt_pkg::ST_EXEC)
   // mirror writes only from the clearing pass or a finishing beat
   `DLWT_ASSERT_IMPL(a_mirror_write_phase, clock, reset,
      mir_wr_en, state_ff == dlwt_pkg::ST_CLEAR || finish)
   // a flush request implies a dirty line in the same response
   `DLWT_ASSERT_IMPL(a_request_dirty, clock, reset,
      rsp_valid_ff && rsp_freq_ff, rsp_any_ff)

endmodule

// ===== bench/tb_dirty_line_writeback_tracker_unit.sv =====
`timescale 1ns / 1ps
module tb_dirty_line_writeback_tracker_unit;
   import dlwt_pkg::*;

   // one request beat as the host offers it
   typedef struct packed {
      op_type            operation;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic [LINE_W-1:0] report_line;
      logic              write_ok;
      logic              verify_ok;
   } tracker_beat_t;

   // one response beat, field for field as the block returns it
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              flush_request;
      logic [LINE_W-1:0] flush_line;
      logic              any_dirty;
      logic              is_healthy;
      logic [CNT_W-1:0]  flush_count;
      logic [CNT_W-1:0]  verify_fail_count;
   } tracker_status_t;

   typedef enum logic { ROW_BEAT, ROW_CSR } row_kind_t;

   // directed table row: either a request beat or a register write
   typedef struct {
      row_kind_t             kind;
      tracker_beat_t         beat;
      logic                  known;
      tracker_status_t       status;
      csr_index_type         csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
   } stim_row_t;

   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_BEATS   = 250;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   dlwt_req_if req_if ();
   dlwt_rsp_if rsp_if ();

   dirty_line_writeback_tracker_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the tracker state, advanced at every accepted request beat
   logic [DATA_W-1:0] shadow_mirror [BUFFER_BYTES];
   logic              shadow_dirty  [NUM_LINES];
   int                shadow_dirty_count;
   logic [CNT_W-1:0]  shadow_idle;
   logic [CNT_W-1:0]  shadow_flushes;
   logic [CNT_W-1:0]  shadow_vfails;
   logic              shadow_verify_en;
   logic [CNT_W-1:0]  shadow_window;

   // response beats still owed by the block, oldest first
   tracker_status_t status_due [$];
   stim_row_t       directed_rows [$];

   int mismatches;
   int beats_checked;
   int flush_requests_seen;
   int unhealthy_seen;

   // idling controls shared between the request side and the response side
   bit                req_gaps_on;
   bit                rsp_stalls_on;
   int                hold_request;
   logic [ADDR_W-1:0] hot_base;

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // lowest dirty line in the shadow bitmap, NUM_LINES when none
   function automatic int lowest_dirty_line();
      for (int k = 0; k < NUM_LINES; k++) begin
         if (shadow_dirty[k]) return k;
      end
      return NUM_LINES;
   endfunction

   // apply one request beat to the shadow state and return the response it causes
   function automatic tracker_status_t step_tracker(input tracker_beat_t b);
      tracker_status_t s;
      int              ln;
      s = '0;
      case (b.operation)
         OP_WRITE: begin
            // only a byte that actually changes marks its line
            if (int'(b.address) < BUFFER_BYTES && shadow_mirror[b.address] != b.write_data) begin
               shadow_mirror[b.address] = b.write_data;
               ln = int'(b.address) >> LINE_SHIFT;
               if (ln < NUM_LINES && !shadow_dirty[ln]) begin
                  shadow_dirty[ln] = 1'b1;
                  shadow_dirty_count++;
               end
            end
         end
         OP_READ: begin
            if (int'(b.address) < BUFFER_BYTES) s.read_data = shadow_mirror[b.address];
         end
         OP_TICK: begin
            // idle count first, health below reflects the new value
            if (shadow_dirty_count == 0) begin
               shadow_idle = '0;
            end else begin
               shadow_idle     = shadow_idle + 1'b1;
               s.flush_request = 1'b1;
               s.flush_line    = LINE_W'(lowest_dirty_line());
            end
         end
         default: begin
            // flush report: nothing at all unless the flash write went through
            if (int'(b.report_line) < NUM_LINES && b.write_ok) begin
               shadow_flushes = shadow_flushes + 1'b1;
               if (shadow_verify_en && !b.verify_ok) begin
                  shadow_vfails = shadow_vfails + 1'b1;
               end else if (shadow_dirty[b.report_line]) begin
                  shadow_dirty[b.report_line] = 1'b0;
                  shadow_dirty_count--;
               end
            end
         end
      endcase
      s.any_dirty         = (shadow_dirty_count != 0);
      s.is_healthy        = (shadow_idle < shadow_window);
      s.flush_count       = shadow_flushes;
      s.verify_fail_count = shadow_vfails;
      return s;
   endfunction

   function automatic tracker_status_t status_of(input int rd, input int req, input int line,
                                                 input int any, input int healthy,
                                                 input int flushes, input int fails);
      tracker_status_t s;
      s.read_data         = DATA_W'(rd);
      s.flush_request     = 1'(req);
      s.flush_line        = LINE_W'(line);
      s.any_dirty         = 1'(any);
      s.is_healthy        = 1'(healthy);
      s.flush_count       = CNT_W'(flushes);
      s.verify_fail_count = CNT_W'(fails);
      return s;
   endfunction

   function automatic stim_row_t beat_row(input op_type op, input int addr, input int data,
                                          input int line, input int wok, input int vok);
      stim_row_t r;
      r.kind             = ROW_BEAT;
      r.beat.operation   = op;
      r.beat.address     = ADDR_W'(addr);
      r.beat.write_data  = DATA_W'(data);
      r.beat.report_line = LINE_W'(line);
      r.beat.write_ok    = 1'(wok);
      r.beat.verify_ok   = 1'(vok);
      r.known            = 1'b0;
      r.status           = '0;
      r.csr_idx          = CSR_VERIFY_ENABLED;
      r.csr_data         = '0;
      return r;
   endfunction

   // row whose response is typed in by hand
   function automatic stim_row_t known_row(input op_type op, input int addr, input int data,
                                           input int line, input int wok, input int vok,
                                           input tracker_status_t st);
      stim_row_t r;
      r        = beat_row(op, addr, data, line, wok, vok);
      r.known  = 1'b1;
      r.status = st;
      return r;
   endfunction

   function automatic stim_row_t csr_row(input csr_index_type idx, input int val);
      stim_row_t r;
      r          = beat_row(OP_READ, 0, 0, 0, 0, 0);
      r.kind     = ROW_CSR;
      r.csr_idx  = idx;
      r.csr_data = CSR_DATA_W'(val);
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // host-like traffic: writes clustered on a hot region, reports aimed at the line a
   // tick would name, unused fields left as noise
   function automatic tracker_beat_t random_beat();
      tracker_beat_t b;
      int            pick;
      int            low;
      b.operation   = OP_TICK;
      b.address     = ADDR_W'($urandom);
      b.write_data  = DATA_W'($urandom);
      b.report_line = LINE_W'($urandom);
      b.write_ok    = 1'($urandom);
      b.verify_ok   = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         b.operation = OP_WRITE;
         if ($urandom_range(0, 99) < 70) b.address = hot_base + ADDR_W'($urandom_range(0, 63));
         // rewrite of the stored value now and then
         if ($urandom_range(0, 9) == 0) b.write_data = shadow_mirror[b.address];
      end else if (pick < 55) begin
         b.operation = OP_READ;
         if ($urandom_range(0, 99) < 60) b.address = hot_base + ADDR_W'($urandom_range(0, 63));
      end else if (pick >= 75) begin
         b.operation = OP_REPORT;
         low = lowest_dirty_line();
         if (low < NUM_LINES && $urandom_range(0, 99) < 70) b.report_line = LINE_W'(low);
         b.write_ok  = ($urandom_range(0, 99) < 85);
         b.verify_ok = ($urandom_range(0, 99) < 80);
      end
      return b;
   endfunction

   // drive one request beat from the falling edge, hold it until taken, then maybe idle
   task automatic offer_beat(input tracker_beat_t b, input logic known,
                             input tracker_status_t fixed);
      tracker_status_t st;
      int              g;
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.operation   <= b.operation;
      req_if.address     <= b.address;
      req_if.write_data  <= b.write_data;
      req_if.report_line <= b.report_line;
      req_if.write_ok    <= b.write_ok;
      req_if.verify_ok   <= b.verify_ok;
      do @(posedge clock); while (!req_if.ready);
      // beat taken at this edge
      st = step_tracker(b);
      status_due.push_back(known ? fixed : st);
      if (req_gaps_on && $urandom_range(0, 99) < 25) begin
         g = gap_length();
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait until every owed response beat is back, plus pipeline slack
   task automatic settle_block();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_VERIFY_ENABLED: shadow_verify_en = val[0];
         default:            shadow_window    = val;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // response side: ready with random stalls, one long hold on request, checks every beat
   initial begin : rsp_side
      int              stall_left;
      int              hold_left;
      tracker_status_t want;
      stall_left   = 0;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_request > 0) begin
            // long hold counted here, the request side keeps offering meanwhile
            hold_left    = hold_request - 1;
            hold_request = 0;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            stall_left   = gap_length() - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (status_due.size() == 0) begin
               $error("response beat with nothing owed");
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("read_data", want.read_data, rsp_if.read_data);
               check_field("flush_request", want.flush_request, rsp_if.flush_request);
               check_field("flush_line", want.flush_line, rsp_if.flush_line);
               check_field("any_dirty", want.any_dirty, rsp_if.any_dirty);
               check_field("is_healthy", want.is_healthy, rsp_if.is_healthy);
               check_field("flush_count", want.flush_count, rsp_if.flush_count);
               check_field("verify_fail_count", want.verify_fail_count,
                           rsp_if.verify_fail_count);
               beats_checked++;
               if (rsp_if.flush_request) flush_requests_seen++;
               if (!rsp_if.is_healthy) unhealthy_seen++;
            end
         end
      end
   end

   // request side and run control
   initial begin : stimulus
      stim_row_t             row;
      logic [CSR_DATA_W-1:0] phase_verify [RANDOM_PHASES];
      logic [CSR_DATA_W-1:0] phase_window [RANDOM_PHASES];

      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_VERIFY_ENABLED;
      csr_write_data     = '0;
      req_if.valid       = 1'b0;
      req_if.operation   = OP_WRITE;
      req_if.address     = '0;
      req_if.write_data  = '0;
      req_if.report_line = '0;
      req_if.write_ok    = 1'b0;
      req_if.verify_ok   = 1'b0;

      mismatches          = 0;
      beats_checked       = 0;
      flush_requests_seen = 0;
      unhealthy_seen      = 0;
      req_gaps_on         = 1'b0;
      rsp_stalls_on       = 1'b0;
      hold_request        = 0;
      hot_base            = '0;

      // shadow state after reset
      for (int i = 0; i < BUFFER_BYTES; i++) shadow_mirror[i] = '0;
      for (int i = 0; i < NUM_LINES; i++) shadow_dirty[i] = 1'b0;
      shadow_dirty_count = 0;
      shadow_idle        = '0;
      shadow_flushes     = '0;
      shadow_vfails      = '0;
      shadow_verify_en   = 1'b1;
      shadow_window      = CNT_W'(HEALTH_WINDOW_RESET);

      // register settings per random phase, extremes of the window among them
      phase_verify = '{16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd1};
      phase_window = '{16'd2000, 16'd1, 16'hFFFF, 16'd5, 16'd3, 16'd2000, 16'd1};

      // directed table
      // reset state: nothing stored, nothing dirty, healthy, counts at zero
      directed_rows.push_back(known_row(OP_READ, 0, 0, 0, 0, 0, status_of(0, 0, 0, 0, 1, 0, 0)));
      directed_rows.push_back(known_row(OP_READ, 16383, 8'hFF, 2047, 1, 1,
                                        status_of(0, 0, 0, 0, 1, 0, 0)));
      // tick with nothing dirty keeps the idle count at zero
      directed_rows.push_back(known_row(OP_TICK, 0, 0, 0, 0, 0, status_of(0, 0, 0, 0, 1, 0, 0)));
      // rewriting the stored zero marks nothing
      directed_rows.push_back(known_row(OP_WRITE, 0, 0, 2047, 1, 1,
                                        status_of(0, 0, 0, 0, 1, 0, 0)));
      // top byte dirties the last line
      directed_rows.push_back(known_row(OP_WRITE, 16383, 8'hFF, 0, 0, 0,
                                        status_of(0, 0, 0, 1, 1, 0, 0)));
      directed_rows.push_back(known_row(OP_READ, 16383, 0, 0, 0, 0,
                                        status_of(8'hFF, 0, 0, 1, 1, 0, 0)));
      directed_rows.push_back(known_row(OP_TICK, 0, 0, 0, 0, 0,
                                        status_of(0, 1, 2047, 1, 1, 0, 0)));
      // lower line takes over as the one to flush
      directed_rows.push_back(beat_row(OP_WRITE, 8, 8'h5A, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_TICK, 0, 0, 0, 0, 0));
      // failed flash write changes nothing
      directed_rows.push_back(beat_row(OP_REPORT, 0, 0, 1, 0, 1));
      // verify failure: flush counted, failure counted, line stays dirty
      directed_rows.push_back(known_row(OP_REPORT, 0, 0, 1, 1, 0,
                                        status_of(0, 0, 0, 1, 1, 1, 1)));
      directed_rows.push_back(beat_row(OP_REPORT, 0, 0, 1, 1, 1));
      // report for a clean line still counts the flush
      directed_rows.push_back(beat_row(OP_REPORT, 0, 0, 5, 1, 1));
      directed_rows.push_back(beat_row(OP_WRITE, 16383, 8'hFF, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_REPORT, 0, 0, 2047, 1, 1));
      directed_rows.push_back(beat_row(OP_TICK, 0, 0, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_WRITE, 100, 8'h80, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_WRITE, 100, 8'h7F, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_READ, 100, 0, 0, 0, 0));
      // verification off: a good write clears even with a bad read-back
      directed_rows.push_back(csr_row(CSR_VERIFY_ENABLED, 0));
      directed_rows.push_back(beat_row(OP_WRITE, 24, 8'h33, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_REPORT, 0, 0, 3, 1, 0));
      directed_rows.push_back(beat_row(OP_REPORT, 0, 0, 3, 0, 0));
      // smallest window: one idle tick with dirty lines is already unhealthy
      directed_rows.push_back(csr_row(CSR_HEALTH_WINDOW, 1));
      directed_rows.push_back(beat_row(OP_TICK, 0, 0, 0, 0, 0));
      directed_rows.push_back(beat_row(OP_REPORT, 16383, 8'hFF, 2047, 1, 1));
      directed_rows.push_back(csr_row(CSR_HEALTH_WINDOW, 16'hFFFF));
      directed_rows.push_back(csr_row(CSR_VERIFY_ENABLED, 1));

      // synchronous reset, released on a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk; the first beat waits out the mirror clearing pass by handshake
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            settle_block();
            write_csr(row.csr_idx, row.csr_data);
         end else begin
            offer_beat(row.beat, row.known, row.status);
         end
      end

      // random phases, each under its own register setting and idling mix
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_block();
         write_csr(CSR_VERIFY_ENABLED, phase_verify[p]);
         write_csr(CSR_HEALTH_WINDOW, phase_window[p]);
         hot_base      = ADDR_W'($urandom);
         // phase 0 runs flat out, phases 4 and 5 idle one side only
         req_gaps_on   = (p != 0) && (p != 5);
         rsp_stalls_on = (p != 0) && (p != 4);
         // one long response hold so the block backs up into its input
         if (p == 2) hold_request = 400;
         repeat (PHASE_BEATS) offer_beat(random_beat(), 1'b0, '0);
      end

      settle_block();
      $display("coverage: %0d response beats checked, %0d flush requests, %0d unhealthy",
               beats_checked, flush_requests_seen, unhealthy_seen);
      $display("coverage: directed corners, %0d random phases of mixed traffic",
               RANDOM_PHASES);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // hang guard, several times the slowest legal run
   initial begin : watchdog
      #(30_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
